FILE: sv/sdpq_pkg.sv
package sdpq_pkg;

	// Queue depth and derived counter width.
	localparam int CAPACITY = 32;
	localparam int CNT_W    = $clog2(CAPACITY + 1);

	// Fixed field widths.
	localparam int ACT_W    = 2;
	localparam int KEY_W    = 16;
	localparam int SERVER_W = 8;
	localparam int TIME_W   = 32;
	localparam int TAG_W    = 16;
	localparam int STATUS_W = 2;
	localparam int OCC_W    = 6;

	// Request action codes; the remaining code leaves the queue unchanged.
	typedef enum logic [ACT_W-1:0] {
		ACT_INSERT     = 2'd0,
		ACT_POP        = 2'd1,
		ACT_REMOVE_DUE = 2'd2
	} action_t;

	// Response status codes.
	typedef enum logic [STATUS_W-1:0] {
		ST_DONE = 2'd0,
		ST_DUP  = 2'd1,
		ST_FULL = 2'd2,
		ST_NONE = 2'd3
	} status_t;

	// Request payload.
	typedef struct packed {
		logic [ACT_W-1:0]    action;
		logic [KEY_W-1:0]    entry_key;
		logic [SERVER_W-1:0] entry_server;
		logic [TIME_W-1:0]   entry_time;
		logic [TAG_W-1:0]    entry_tag;
		logic [TIME_W-1:0]   due_time;
	} in_item_t;

	// Response payload.
	typedef struct packed {
		status_t             status;
		logic [KEY_W-1:0]    out_key;
		logic [SERVER_W-1:0] out_server;
		logic [TIME_W-1:0]   out_time;
		logic [TAG_W-1:0]    out_tag;
		logic [OCC_W-1:0]    occupancy;
	} out_item_t;

	// Descriptor contents held by one cell.
	typedef struct packed {
		logic [KEY_W-1:0]    key;
		logic [SERVER_W-1:0] server;
		logic [TIME_W-1:0]   stamp;
		logic [TAG_W-1:0]    tag;
	} slot_data_t;

	// Descriptor with its occupancy bit, as passed between neighbours.
	typedef struct packed {
		logic       valid;
		slot_data_t data;
	} slot_t;

	// Controls broadcast from the sequencer to every cell.
	typedef struct packed {
		logic capture;
		logic commit_ins;
		logic commit_rm;
		logic pop_mode;
	} cell_ctl_t;

endpackage

FILE: sv/sdpq_cell.sv
module sdpq_cell
	import sdpq_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  cell_ctl_t  ctl,
	input  in_item_t   req,
	input  slot_data_t new_data,
	input  logic       head,
	input  slot_t      left,
	input  logic       left_le,
	input  slot_t      right,
	input  logic       rm_in,
	output slot_t      slot,
	output logic       le,
	output logic       match,
	output logic       rm_out,
	output logic       sel
);

	logic       valid_q;
	slot_data_t data_q;
	logic       le_q;
	logic       match_q;
	logic       due_q;
	logic       hit;
	slot_t      nxt;

	assign slot.valid = valid_q;
	assign slot.data  = data_q;
	assign le         = le_q;
	assign match      = match_q;

	// Compare flags are taken against the request as it is transferred in.
	always_ff @(posedge clk) begin
		if (ctl.capture) begin
			le_q    <= valid_q && (data_q.key <= req.entry_key);
			match_q <= valid_q && (data_q.key == req.entry_key)
			           && (data_q.server == req.entry_server);
			due_q   <= valid_q && (data_q.stamp <= req.due_time);
		end
	end

	// The removal region starts at the first hit and runs to the tail.
	always_comb begin
		hit    = valid_q && (ctl.pop_mode ? head : due_q);
		rm_out = rm_in | hit;
		sel    = hit & ~rm_in;
	end

	// A removal pulls from the right; an insert keeps, takes the new entry or
	// takes the left neighbour depending on where the key boundary falls.
	always_comb begin
		nxt.valid = valid_q;
		nxt.data  = data_q;
		priority if (ctl.commit_rm && rm_out) begin
			nxt = right;
		end else if (ctl.commit_ins && !le_q) begin
			if (left_le) begin
				nxt.valid = 1'b1;
				nxt.data  = new_data;
			end else begin
				nxt = left;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= nxt.valid;
		end
	end

	always_ff @(posedge clk) begin
		data_q <= nxt.data;
	end

endmodule

FILE: sv/sorted_dedup_priority_queue.sv
// Sorted descriptor queue of CAPACITY entries held in a row of cells, lowest
// key at the head, equal keys kept in arrival order. Each request is handled
// thus: in the cycle it is transferred every cell registers its compare
// flags against the request, and then in a shift cycle all cells shift
// left or right by one place at once, with the response loaded into the
// output register. A waiting response does not block the next request;
// the shift cycle is held back only while the previous response is still
// stalled. An insert is refused as a duplicate when any held entry has the
// same key and server, and as full when CAPACITY entries are held; pop and
// remove-due report status 3 when nothing is removed. Data fields of a
// response that removed nothing are zero.
module sorted_dedup_priority_queue
	import sdpq_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	output logic      req_stall,
	input  in_item_t  req,
	output logic      rsp_valid,
	input  logic      rsp_stall,
	output out_item_t rsp
);

	logic                busy_q;
	in_item_t            cmd_q;
	logic [CNT_W-1:0]    count_q;
	logic [CNT_W-1:0]    count_next;
	logic                rsp_valid_q;
	out_item_t           rsp_q;
	logic                accept;
	logic                commit;
	logic                is_ins;
	logic                is_rm;
	logic                dup;
	logic                full;
	logic                any_sel;
	logic                ins_ok;
	cell_ctl_t           ctl;
	slot_data_t          new_data;
	slot_data_t          removed;
	slot_t               slots [CAPACITY];
	logic [CAPACITY-1:0] le_vec;
	logic [CAPACITY-1:0] match_vec;
	logic [CAPACITY-1:0] rm_vec;
	logic [CAPACITY-1:0] sel_vec;
	logic [CAPACITY-1:0] valid_vec;
	out_item_t           rsp_next;

	// Handshake and sequencing.
	assign req_stall = busy_q;
	assign accept    = req_valid && !busy_q;
	assign commit    = busy_q && (!rsp_valid_q || !rsp_stall);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// Decode of the held request and the queue-wide flags.
	always_comb begin
		is_ins  = (cmd_q.action == ACT_INSERT);
		is_rm   = (cmd_q.action == ACT_POP) || (cmd_q.action == ACT_REMOVE_DUE);
		dup     = |match_vec;
		full    = (count_q >= CNT_W'(CAPACITY));
		any_sel = |sel_vec;
		ins_ok  = is_ins && !dup && !full;

		ctl.capture    = accept;
		ctl.commit_ins = commit && ins_ok;
		ctl.commit_rm  = commit && is_rm;
		ctl.pop_mode   = (cmd_q.action == ACT_POP);

		new_data.key    = cmd_q.entry_key;
		new_data.server = cmd_q.entry_server;
		new_data.stamp  = cmd_q.entry_time;
		new_data.tag    = cmd_q.entry_tag;
	end

	// The row of cells.
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		slot_t left_s;
		slot_t right_s;
		logic  left_le_s;
		logic  rm_in_s;

		if (i == 0) begin : g_first
			assign left_s    = '0;
			assign left_le_s = 1'b1;
			assign rm_in_s   = 1'b0;
		end else begin : g_mid
			assign left_s    = slots[i-1];
			assign left_le_s = le_vec[i-1];
			assign rm_in_s   = rm_vec[i-1];
		end

		if (i == CAPACITY - 1) begin : g_last
			assign right_s = '0;
		end else begin : g_inner
			assign right_s = slots[i+1];
		end

		sdpq_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctl      (ctl),
			.req      (req),
			.new_data (new_data),
			.head     (i == 0),
			.left     (left_s),
			.left_le  (left_le_s),
			.right    (right_s),
			.rm_in    (rm_in_s),
			.slot     (slots[i]),
			.le       (le_vec[i]),
			.match    (match_vec[i]),
			.rm_out   (rm_vec[i]),
			.sel      (sel_vec[i])
		);

		assign valid_vec[i] = slots[i].valid;
	end

	// The removed descriptor is picked out by the one selected cell.
	always_comb begin
		removed = '0;
		for (int j = 0; j < CAPACITY; j++) begin
			if (sel_vec[j]) begin
				removed = removed | slots[j].data;
			end
		end
	end

	// Fill count and response contents.
	always_comb begin
		count_next = count_q;
		rsp_next   = '0;
		priority if (is_ins) begin
			if (dup) begin
				rsp_next.status = ST_DUP;
			end else if (full) begin
				rsp_next.status = ST_FULL;
			end else begin
				rsp_next.status = ST_DONE;
				count_next      = count_q + CNT_W'(1);
			end
		end else if (is_rm && any_sel) begin
			rsp_next.status     = ST_DONE;
			rsp_next.out_key    = removed.key;
			rsp_next.out_server = removed.server;
			rsp_next.out_time   = removed.stamp;
			rsp_next.out_tag    = removed.tag;
			count_next          = count_q - CNT_W'(1);
		end else begin
			rsp_next.status = ST_NONE;
		end
		rsp_next.occupancy = OCC_W'(count_next);
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				busy_q <= 1'b1;
			end else if (commit) begin
				busy_q <= 1'b0;
			end
			if (commit) begin
				count_q     <= count_next;
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q <= req;
		end
		if (commit) begin
			rsp_q <= rsp_next;
		end
	end

	// The fill count never passes the depth.
	assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(CAPACITY))
		else $error("fill count above capacity");

	// The number of held entries equals the fill count.
	assert property (@(posedge clk) disable iff (!arst_n)
		$countones(valid_vec) == int'(count_q))
		else $error("valid cells disagree with fill count");

	// At most one cell gives up its entry in a removal.
	assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> $onehot0(sel_vec))
		else $error("more than one cell selected for removal");

	// A shift cycle always produces a response in the next cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		commit |=> rsp_valid_q && !busy_q)
		else $error("commit did not load the response register");

endmodule
